FILE: hw/rtl/abc_pkg.sv
`default_nettype none
package abc_pkg;

    // Rotator word width: sine and cosine Q2.30 plus headroom, angles in turns with 32 fraction bits.
    localparam int SC_W = 34;
    // Products of an amplitude and a sine or cosine, and their sums.
    localparam int PR_W = 50;
    localparam int SUM_W = 52;
    // Sums scaled by the wavenumber.
    localparam int SCL_W = 70;

    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic signed [SC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [1:0] REG_AMP_A = 2'd0;
    localparam logic [1:0] REG_AMP_B = 2'd1;
    localparam logic [1:0] REG_AMP_C = 2'd2;
    localparam logic [1:0] REG_WAVENUM = 2'd3;

    typedef logic signed [SC_W-1:0] t_sc;

    function automatic int cordic_iters(input int angle_bits);
        int n;
        n = angle_bits + 4;
        if (n > ATAN_ENTRIES) begin
            n = ATAN_ENTRIES;
        end
        return n;
    endfunction

    // Arctangent of 2^-i as a fraction of a turn in Q0.32.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Round half up at bit s-1, shift right by s and saturate to 32 bits.
    function automatic logic [31:0] rnd_sat(input logic signed [SCL_W-1:0] v, input int s);
        logic signed [SCL_W-1:0] r;
        logic [31:0] o;
        r = (v + (70'sd1 <<< (s - 1))) >>> s;
        if (r > 70'sd2147483647) begin
            o = 32'h7FFFFFFF;
        end else if (r < -70'sd2147483648) begin
            o = 32'h80000000;
        end else begin
            o = r[31:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/abc_if.sv
`default_nettype none
interface abc_pos_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface abc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] strain_xy;
    logic [31:0] strain_xz;
    logic [31:0] strain_yz;
    logic [31:0] rot_x;
    logic [31:0] rot_y;
    logic [31:0] rot_z;
    modport source (output valid, output vel_x, output vel_y, output vel_z,
                    output strain_xy, output strain_xz, output strain_yz,
                    output rot_x, output rot_y, output rot_z, input ready);
    modport sink (input valid, input vel_x, input vel_y, input vel_z,
                  input strain_xy, input strain_xz, input strain_yz,
                  input rot_x, input rot_y, input rot_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/abc_sincos.sv
`default_nettype none
module abc_sincos #(
    parameter int ANGLE_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_pos,
    input  wire logic [15:0] i_k,
    output abc_pkg::t_sc     o_sin,
    output abc_pkg::t_sc     o_cos
);
    import abc_pkg::*;

    localparam int NIT = cordic_iters(ANGLE_BITS);
    localparam logic [31:0] QMASK = 32'hFFFFFFFF << (32 - ANGLE_BITS);

    // Phase k*pos in Q24.24.
    logic signed [48:0] r_phase;
    // Partial products of the turn conversion.
    logic [53:0] r_plo;
    logic [31:0] r_phi;

    t_sc  r_x [0:NIT];
    t_sc  r_y [0:NIT];
    t_sc  r_z [0:NIT];
    logic r_neg [0:NIT];
    t_sc  r_sin;
    t_sc  r_cos;

    logic signed [24:0] phase_hi;
    logic signed [55:0] phi_full;
    logic [31:0]        turn;
    logic signed [SC_W-1:0] n_z;
    logic               n_neg;

    assign phase_hi = 25'(r_phase >>> 24);
    assign phi_full = phase_hi * $signed({1'b0, INV_TWO_PI});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= $signed(i_pos) * $signed({1'b0, i_k});
            r_plo   <= r_phase[23:0] * INV_TWO_PI;
            r_phi   <= phi_full[31:0];
        end
    end

    // Quantise the turn and fold it into [-1/4, 1/4].
    always_comb begin
        turn  = (32'(r_plo[53:24]) + r_phi) & QMASK;
        n_z   = SC_W'($signed(turn));
        n_neg = 1'b0;
        if (n_z > 34'sd1073741824) begin
            n_z   = n_z - 34'sd2147483648;
            n_neg = 1'b1;
        end else if (n_z < -34'sd1073741824) begin
            n_z   = n_z + 34'sd2147483648;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_X0;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - $signed({2'b00, atan_turn(5'(i))});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + $signed({2'b00, atan_turn(5'(i))});
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_neg[NIT] ? -r_y[NIT] : r_y[NIT];
            r_cos <= r_neg[NIT] ? -r_x[NIT] : r_x[NIT];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

FILE: hw/rtl/abc_mix.sv
`default_nettype none
module abc_mix (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  abc_pkg::t_sc     i_sx,
    input  abc_pkg::t_sc     i_cx,
    input  abc_pkg::t_sc     i_sy,
    input  abc_pkg::t_sc     i_cy,
    input  abc_pkg::t_sc     i_sz,
    input  abc_pkg::t_sc     i_cz,
    input  wire logic [15:0] i_amp_a,
    input  wire logic [15:0] i_amp_b,
    input  wire logic [15:0] i_amp_c,
    input  wire logic [15:0] i_k,
    output logic      [31:0] o_res [0:8]
);
    import abc_pkg::*;

    logic signed [PR_W-1:0]  r_pr  [0:5];
    logic signed [SUM_W-1:0] r_sum [0:5];
    logic signed [SCL_W-1:0] r_vel [0:2];
    logic signed [SCL_W-1:0] r_scl [0:5];
    logic [31:0]             r_res [0:8];
    logic signed [16:0]      ks;

    assign ks = $signed({1'b0, i_k});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Products in Q.42: a*cz, c*sy, b*cx, a*sz, c*cy, b*sx.
            r_pr[0] <= PR_W'($signed(i_amp_a) * i_cz);
            r_pr[1] <= PR_W'($signed(i_amp_c) * i_sy);
            r_pr[2] <= PR_W'($signed(i_amp_b) * i_cx);
            r_pr[3] <= PR_W'($signed(i_amp_a) * i_sz);
            r_pr[4] <= PR_W'($signed(i_amp_c) * i_cy);
            r_pr[5] <= PR_W'($signed(i_amp_b) * i_sx);

            // Velocity sums first, then strain differences.
            r_sum[0] <= SUM_W'(r_pr[0]) + SUM_W'(r_pr[1]);
            r_sum[1] <= SUM_W'(r_pr[2]) + SUM_W'(r_pr[3]);
            r_sum[2] <= SUM_W'(r_pr[4]) + SUM_W'(r_pr[5]);
            r_sum[3] <= SUM_W'(r_pr[2]) - SUM_W'(r_pr[1]);
            r_sum[4] <= SUM_W'(r_pr[0]) - SUM_W'(r_pr[5]);
            r_sum[5] <= SUM_W'(r_pr[4]) - SUM_W'(r_pr[3]);

            for (int j = 0; j < 3; j++) begin
                r_vel[j] <= SCL_W'(r_sum[j]);
            end
            for (int j = 0; j < 6; j++) begin
                r_scl[j] <= SCL_W'(r_sum[j] * ks);
            end

            for (int j = 0; j < 3; j++) begin
                r_res[j]     <= rnd_sat(r_vel[j], 26);
                r_res[j + 3] <= rnd_sat(r_scl[j + 3], 34);
                r_res[j + 6] <= rnd_sat(r_scl[j], 35);
            end
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

FILE: hw/rtl/abc_flow_field_eval.sv
// ABC flow evaluator.
// A particle position (Q16.16) arrives as a beat on the position channel; one beat
// leaves on the result channel with the velocity, the three off-diagonal strain
// terms and the rotation vector, all Q16.16, rounded and saturated.
// Both channels use valid/ready; a beat moves when both are high.
// Amplitudes A, B, C and the wavenumber k sit in an APB register file at byte
// addresses 0, 4, 8 and 12; they are to be written while no beat is in flight.
// The pipeline registers, in order: the phase multiply, the turn conversion,
// the folding, one rotator stage per iteration (ANGLE_BITS + 4 of them, capped
// at the arctangent table size), the sign fix, and then the amplitude
// products, sums, wavenumber scaling and rounding.
// Throughput is one beat per cycle while the receiver takes results: the three rotators are fully pipelined.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// the position channel deasserts ready; nothing is lost or repeated.
// Reset clears the valid bits of every stage and returns the registers to
// A = B = C = 1.0 and k = 5.0.
`default_nettype none
module abc_flow_field_eval #(
    parameter int ANGLE_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    abc_pos_if.sink          i_pos,
    abc_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import abc_pkg::*;

    localparam int LAT = cordic_iters(ANGLE_BITS) + 8;

    logic [15:0] r_amp_a;
    logic [15:0] r_amp_b;
    logic [15:0] r_amp_c;
    logic [15:0] r_wavenum;
    logic [LAT-1:0] r_vld;

    logic en;
    logic wr;
    t_sc  sx, cx, sy, cy, sz, cz;
    logic [31:0] res [0:8];

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_a   <= 16'd4096;
            r_amp_b   <= 16'd4096;
            r_amp_c   <= 16'd4096;
            r_wavenum <= 16'd1280;
        end else if (wr) begin
            case (paddr[3:2])
                REG_AMP_A:   r_amp_a   <= pwdata[15:0];
                REG_AMP_B:   r_amp_b   <= pwdata[15:0];
                REG_AMP_C:   r_amp_c   <= pwdata[15:0];
                REG_WAVENUM: r_wavenum <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AMP_A:   prdata = {16'd0, r_amp_a};
            REG_AMP_B:   prdata = {16'd0, r_amp_b};
            REG_AMP_C:   prdata = {16'd0, r_amp_c};
            REG_WAVENUM: prdata = {16'd0, r_wavenum};
            default:     prdata = 32'd0;
        endcase
    end

    // The pipeline advances whenever the output stage is empty or being drained.
    assign en          = !r_vld[LAT-1] || o_res.ready;
    assign i_pos.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_pos.valid};
        end
    end

    abc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos.pos_x), .i_k(r_wavenum),
        .o_sin(sx), .o_cos(cx)
    );
    abc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos.pos_y), .i_k(r_wavenum),
        .o_sin(sy), .o_cos(cy)
    );
    abc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos.pos_z), .i_k(r_wavenum),
        .o_sin(sz), .o_cos(cz)
    );

    abc_mix u_mix (
        .i_clk(i_clk), .i_en(en),
        .i_sx(sx), .i_cx(cx), .i_sy(sy), .i_cy(cy), .i_sz(sz), .i_cz(cz),
        .i_amp_a(r_amp_a), .i_amp_b(r_amp_b), .i_amp_c(r_amp_c), .i_k(r_wavenum),
        .o_res(res)
    );

    assign o_res.valid     = r_vld[LAT-1];
    assign o_res.vel_x     = res[0];
    assign o_res.vel_y     = res[1];
    assign o_res.vel_z     = res[2];
    assign o_res.strain_xy = res[3];
    assign o_res.strain_xz = res[4];
    assign o_res.strain_yz = res[5];
    assign o_res.rot_x     = res[6];
    assign o_res.rot_y     = res[7];
    assign o_res.rot_z     = res[8];

endmodule
`default_nettype wire
